### rtl/kmer_count_table_unit_defines.svh
// assertion macros for the key frequency table
`ifndef KMER_COUNT_TABLE_UNIT_DEFINES_SVH
`define KMER_COUNT_TABLE_UNIT_DEFINES_SVH
// implication checked on every edge outside reset
`define KCT_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("kct check failed");
// next-cycle implication outside reset
`define KCT_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("kct check failed");
`endif

### rtl/kct_pkg.sv
// shared types and codes of the key frequency table
`timescale 1ns / 1ps
`default_nettype none
package kct_pkg;
  localparam logic [2:0] REQ_ADD = 3'd0;
  localparam logic [2:0] REQ_CLEAR = 3'd1;
  localparam logic [2:0] REQ_COVER = 3'd2;
  localparam logic [2:0] REQ_TOP = 3'd3;
  localparam logic [2:0] REQ_MERGE = 3'd4;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;
  localparam logic [3:0] NIBBLE_MASK = 4'hf;
  localparam int NIBBLE_SLOTS = 16;
  localparam int KEY_BITS = 16;
  localparam int OUT_COUNT_BITS = 24;

  typedef struct packed {
    logic         rd_en;
    logic         wr_en;
  } mem_ctl_t;
endpackage
`default_nettype wire

### rtl/kct_store.sv
// key and count memory with one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module kct_store #(
  parameter int DEPTH = 64,
  parameter int AW = 6,
  parameter int CW = 24
) (
  input  wire logic                    clk,
  input  wire kct_pkg::mem_ctl_t       ctl,
  input  wire logic [AW-1:0]           rd_addr,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic [15:0]             wr_key,
  input  wire logic [CW-1:0]           wr_count,
  output logic      [15:0]             rd_key,
  output logic      [CW-1:0]           rd_count
);
  import kct_pkg::*;
  logic [15:0]   key_mem [DEPTH];
  logic [CW-1:0] count_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      key_mem[wr_addr] <= wr_key;
      count_mem[wr_addr] <= wr_count;
    end
    if (ctl.rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_count <= count_mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

### rtl/kmer_count_table_unit.sv
// top level of the key frequency table
// One request is taken when start is high and busy is low; busy then stays high up to and
// including the cycle of the last result strobe. Add, coverage, top-n and merge requests walk
// the stored entries through the single memory read port, so their busy time grows with
// used_entries (an add stops at the matching entry); merge adds a write-back of the sixteen
// nibble slots, clear and unknown requests skip the walk, and top-n repeats a full scan per
// listed entry, or a single scan when nothing is listed. Results appear for one cycle each
// on valid with last marking the final one; the receiver cannot stall, so results must be
// taken as shown.
`timescale 1ns / 1ps
`default_nettype none
module kmer_count_table_unit #(
  parameter int TABLE_DEPTH = 64,
  parameter int TOP_MAX = 8,
  parameter int COUNT_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] kmer_key,
  input  wire logic [3:0]  rank_limit,
  output logic             valid,
  output logic [15:0]      entry_key,
  output logic [23:0]      entry_count,
  output logic             entry_valid,
  output logic [23:0]      base_sum,
  output logic [23:0]      total_seen,
  output logic [1:0]       status,
  output logic             last
);
  import kct_pkg::*;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = $clog2(TOP_MAX + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_WAIT  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_FIN   = 7'b0010000,
    S_MWR   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [2:0] req;
  logic [15:0] qkey;
  logic [TW-1:0] n_top, k_top;
  logic [UW-1:0] used, idx, fill;
  logic [COUNT_BITS-1:0] total, acc, best_c, prev_c;
  logic [AW-1:0] best_i, prev_i, hit_i;
  logic got, found, sat;
  logic [15:0] best_k;
  logic have [NIBBLE_SLOTS];
  logic [AW-1:0] slot [NIBBLE_SLOTS];
  logic [COUNT_BITS-1:0] mcnt [NIBBLE_SLOTS];

  mem_ctl_t ctl;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [15:0] wr_key, rd_key;
  logic [COUNT_BITS-1:0] wr_count, rd_count;
  logic [AW-1:0] ridx;
  logic [3:0] nib;
  logic [COUNT_BITS:0] sum_w;

  kct_store #(.DEPTH(TABLE_DEPTH), .AW(AW), .CW(COUNT_BITS)) u_store (
    .clk(clk), .ctl(ctl), .rd_addr(rd_addr), .wr_addr(wr_addr), .wr_key(wr_key),
    .wr_count(wr_count), .rd_key(rd_key), .rd_count(rd_count)
  );

  assign busy = (state != S_IDLE);
  assign valid = (state == S_OUT);
  assign ridx = AW'(idx - UW'(1));
  assign nib = rd_key[3:0] & NIBBLE_MASK;
  assign rd_addr = idx[AW-1:0];

  always_comb begin
    ctl.rd_en = (state == S_SCAN);
    ctl.wr_en = 1'b0;
    wr_addr = hit_i;
    wr_key = qkey;
    wr_count = acc;
    sum_w = '0;
    if (state == S_EVAL && req == REQ_COVER)
      sum_w = {1'b0, acc} + {1'b0, rd_count};
    if (state == S_EVAL && req == REQ_MERGE && have[nib])
      sum_w = {1'b0, mcnt[nib]} + {1'b0, rd_count};
    if (state == S_FIN && req == REQ_ADD) begin
      if (found) begin
        ctl.wr_en = (acc != CMAX);
        wr_count = acc + COUNT_BITS'(1);
      end else begin
        ctl.wr_en = (used < UW'(TABLE_DEPTH));
        wr_addr = used[AW-1:0];
        wr_count = COUNT_BITS'(1);
      end
    end
    if (state == S_MWR) begin
      ctl.wr_en = have[idx[3:0]];
      wr_addr = slot[idx[3:0]];
      wr_key = {12'd0, idx[3:0]};
      wr_count = mcnt[idx[3:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      total <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          req <= req_type;
          qkey <= kmer_key;
          n_top <= (32'(rank_limit) > 32'(TOP_MAX)) ? TW'(TOP_MAX) : TW'(rank_limit);
          k_top <= '0;
          idx <= '0;
          acc <= '0;
          found <= 1'b0;
          got <= 1'b0;
          sat <= 1'b0;
          fill <= '0;
          for (int j = 0; j < NIBBLE_SLOTS; j++) have[j] <= 1'b0;
          entry_key <= '0;
          entry_count <= '0;
          entry_valid <= 1'b0;
          base_sum <= '0;
          status <= ST_OK;
          last <= 1'b1;
          if (req_type == REQ_CLEAR) begin
            used <= '0;
            total <= '0;
            state <= S_OUT;
          end else if (req_type == REQ_ADD || req_type == REQ_COVER ||
                       req_type == REQ_TOP || req_type == REQ_MERGE)
            state <= S_SCAN;
          else
            state <= S_OUT;
        end
        S_SCAN: begin
          if (idx >= used || (req == REQ_ADD && found)) state <= S_FIN;
          else begin
            idx <= idx + UW'(1);
            state <= S_WAIT;
          end
        end
        S_WAIT: state <= S_EVAL;
        S_EVAL: begin
          state <= S_SCAN;
          unique case (req)
            REQ_ADD: if (rd_key == qkey) begin
              found <= 1'b1;
              hit_i <= ridx;
              acc <= rd_count;
            end
            REQ_COVER: if ({12'd0, nib} == qkey) begin
              if (sum_w[COUNT_BITS]) acc <= CMAX;
              else acc <= sum_w[COUNT_BITS-1:0];
            end
            REQ_TOP: if (k_top == '0 || rd_count < prev_c ||
                         (rd_count == prev_c && ridx > prev_i)) begin
              if (!got || rd_count > best_c) begin
                got <= 1'b1;
                best_c <= rd_count;
                best_i <= ridx;
                best_k <= rd_key;
              end
            end
            default: begin
              if (!have[nib]) begin
                have[nib] <= 1'b1;
                slot[nib] <= fill[AW-1:0];
                mcnt[nib] <= rd_count;
                fill <= fill + UW'(1);
              end else if (sum_w[COUNT_BITS]) begin
                mcnt[nib] <= CMAX;
                sat <= 1'b1;
              end else mcnt[nib] <= sum_w[COUNT_BITS-1:0];
            end
          endcase
        end
        S_FIN: begin
          state <= S_OUT;
          unique case (req)
            REQ_ADD: begin
              if (total != CMAX) total <= total + COUNT_BITS'(1);
              if (!found && used >= UW'(TABLE_DEPTH)) status <= ST_FULL;
              else if ((found && acc == CMAX) || total == CMAX) status <= ST_SAT;
              if (!found && used < UW'(TABLE_DEPTH)) used <= used + UW'(1);
            end
            REQ_COVER: base_sum <= 24'(acc);
            REQ_TOP: begin
              if (n_top == '0 || used == '0) last <= 1'b1;
              else begin
                entry_key <= best_k;
                entry_count <= 24'(best_c);
                entry_valid <= 1'b1;
                prev_c <= best_c;
                prev_i <= best_i;
                last <= (UW'(k_top) + UW'(1) >= used) || (k_top + TW'(1) == n_top);
              end
            end
            default: begin
              idx <= '0;
              status <= sat ? ST_SAT : ST_OK;
              state <= S_MWR;
            end
          endcase
        end
        S_MWR: begin
          if (idx == UW'(NIBBLE_SLOTS - 1)) begin
            used <= fill;
            state <= S_OUT;
          end else idx <= idx + UW'(1);
        end
        default: begin
          if (req == REQ_TOP && !last) begin
            k_top <= k_top + TW'(1);
            idx <= '0;
            got <= 1'b0;
            state <= S_SCAN;
          end else state <= S_IDLE;
        end
      endcase
    end
  end
  assign total_seen = 24'(total);
endmodule
`default_nettype wire

### rtl/kct_checker.sv
// port level checks of the key frequency table
`timescale 1ns / 1ps
`default_nettype none
`include "kmer_count_table_unit_defines.svh"
module kct_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic valid,
  input wire logic last,
  input wire logic entry_valid,
  input wire logic [23:0] base_sum,
  input wire logic [1:0] status
);
  import kct_pkg::*;
  `KCT_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `KCT_ASSERT_NXT(a_last_idle, valid && last, !busy)
  `KCT_ASSERT_IMP(a_valid_busy, valid, busy)
  `KCT_ASSERT_IMP(a_entry_no_sum, valid && entry_valid, base_sum == 24'd0 && status == ST_OK)
endmodule
bind kmer_count_table_unit kct_checker u_kct_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .valid(valid), .last(last),
  .entry_valid(entry_valid), .base_sum(base_sum), .status(status)
);
`default_nettype wire

### tb/kmer_count_table_unit_tb.sv
// self-checking testbench for the key frequency table unit
`timescale 1ns / 1ps
`default_nettype none
module kmer_count_table_unit_tb;
  import kct_pkg::*;

  localparam int DEPTH = 64;
  localparam int TOPN = 8;
  localparam logic [23:0] CNT_MAX = 24'hffffff;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 600;
  localparam logic [2:0] REQ_BAD_LO = 3'd5;
  localparam logic [2:0] REQ_BAD_MID = 3'd6;
  localparam logic [2:0] REQ_BAD_HI = 3'd7;

  typedef struct packed {
    logic [15:0] key;
    logic [23:0] cnt;
    logic        ev;
    logic [23:0] sum;
    logic [23:0] tot;
    logic [1:0]  st;
    logic        lst;
  } table_result_t;

  typedef struct packed {
    logic [2:0]  req;
    logic [15:0] key;
    logic [3:0]  lim;
    logic        typed;
    logic [1:0]  st;
    logic [23:0] sum;
    logic [23:0] tot;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] req_type = REQ_ADD;
  logic [15:0] kmer_key = '0;
  logic [3:0] rank_limit = '0;
  logic busy, valid, entry_valid, last;
  logic [15:0] entry_key;
  logic [23:0] entry_count, base_sum, total_seen;
  logic [1:0] status;

  // model copy of the table
  logic [15:0] model_keys [DEPTH];
  logic [23:0] model_counts [DEPTH];
  int model_used;
  logic [23:0] model_total;
  table_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  logic [15:0] key_pool [80];

  kmer_count_table_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .kmer_key(kmer_key), .rank_limit(rank_limit), .valid(valid),
    .entry_key(entry_key), .entry_count(entry_count), .entry_valid(entry_valid),
    .base_sum(base_sum), .total_seen(total_seen), .status(status), .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[kmer_count_table_unit] ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic table_result_t plain_result(input logic [1:0] st, input logic [23:0] sum);
    table_result_t r;
    r = '0;
    r.sum = sum;
    r.tot = model_total;
    r.st = st;
    r.lst = 1'b1;
    return r;
  endfunction

  task automatic predict_request(input logic [2:0] req, input logic [15:0] key,
                                 input logic [3:0] lim);
    logic [24:0] acc;
    logic sat, found;
    logic [1:0] st;
    int n, best_i, prev_i, fill;
    logic [23:0] best_c, prev_c;
    logic got;
    int slot [NIBBLE_SLOTS];
    logic have [NIBBLE_SLOTS];
    table_result_t r;
    sat = 1'b0;
    found = 1'b0;
    st = ST_OK;
    case (req)
      REQ_ADD: begin
        for (int i = 0; i < model_used; i++) begin
          if (!found && model_keys[i] == key) begin
            found = 1'b1;
            if (model_counts[i] == CNT_MAX) sat = 1'b1;
            else model_counts[i]++;
          end
        end
        if (!found) begin
          if (model_used < DEPTH) begin
            model_keys[model_used] = key;
            model_counts[model_used] = 24'd1;
            model_used++;
          end else st = ST_FULL;
        end
        if (model_total == CNT_MAX) sat = 1'b1;
        else model_total++;
        if (st == ST_OK && sat) st = ST_SAT;
        pending_results.push_back(plain_result(st, '0));
      end
      REQ_CLEAR: begin
        model_used = 0;
        model_total = '0;
        pending_results.push_back(plain_result(ST_OK, '0));
      end
      REQ_COVER: begin
        acc = '0;
        for (int i = 0; i < model_used; i++) begin
          if ({12'd0, model_keys[i][3:0]} == key) begin
            acc = acc + model_counts[i];
            if (acc > CNT_MAX) acc = CNT_MAX;
          end
        end
        pending_results.push_back(plain_result(ST_OK, acc[23:0]));
      end
      REQ_TOP: begin
        n = (lim > TOPN) ? TOPN : lim;
        if (n > model_used) n = model_used;
        if (n == 0) pending_results.push_back(plain_result(ST_OK, '0));
        prev_c = '0;
        prev_i = 0;
        for (int k = 0; k < n; k++) begin
          got = 1'b0;
          best_c = '0;
          best_i = 0;
          for (int i = 0; i < model_used; i++) begin
            if (k == 0 || model_counts[i] < prev_c ||
                (model_counts[i] == prev_c && i > prev_i)) begin
              if (!got || model_counts[i] > best_c) begin
                got = 1'b1;
                best_c = model_counts[i];
                best_i = i;
              end
            end
          end
          prev_c = best_c;
          prev_i = best_i;
          r = plain_result(ST_OK, '0);
          r.key = model_keys[best_i];
          r.cnt = best_c;
          r.ev = 1'b1;
          r.lst = (k + 1 == n);
          pending_results.push_back(r);
        end
      end
      REQ_MERGE: begin
        fill = 0;
        for (int j = 0; j < NIBBLE_SLOTS; j++) begin
          have[j] = 1'b0;
          slot[j] = 0;
        end
        for (int i = 0; i < model_used; i++) begin
          if (!have[model_keys[i][3:0]]) begin
            have[model_keys[i][3:0]] = 1'b1;
            slot[model_keys[i][3:0]] = fill;
            model_counts[fill] = model_counts[i];
            model_keys[fill] = {12'd0, model_keys[i][3:0]};
            fill++;
          end else begin
            acc = model_counts[slot[model_keys[i][3:0]]] + model_counts[i];
            if (acc > CNT_MAX) begin
              acc = CNT_MAX;
              sat = 1'b1;
            end
            model_counts[slot[model_keys[i][3:0]]] = acc[23:0];
          end
        end
        model_used = fill;
        pending_results.push_back(plain_result(sat ? ST_SAT : ST_OK, '0));
      end
      default: pending_results.push_back(plain_result(ST_OK, '0));
    endcase
  endtask

  // drives one request; the expectation is queued once acceptance is certain
  task automatic send_request(input logic [2:0] req, input logic [15:0] key,
                              input logic [3:0] lim, input logic typed,
                              input table_result_t typed_result);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    req_type = req;
    kmer_key = key;
    rank_limit = lim;
    while (busy) @(negedge clk);
    predict_request(req, key, lim);
    if (typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(typed_result);
    end
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (!rst && valid) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", {8'd0, entry_key}, '0);
      end else begin
        want = pending_results.pop_front();
        if (entry_key !== want.key) report("entry_key", {8'd0, entry_key}, {8'd0, want.key});
        if (entry_count !== want.cnt) report("entry_count", entry_count, want.cnt);
        if (entry_valid !== want.ev) report("entry_valid", {23'd0, entry_valid}, {23'd0, want.ev});
        if (base_sum !== want.sum) report("base_sum", base_sum, want.sum);
        if (total_seen !== want.tot) report("total_seen", total_seen, want.tot);
        if (status !== want.st) report("status", {22'd0, status}, {22'd0, want.st});
        if (last !== want.lst) report("last", {23'd0, last}, {23'd0, want.lst});
      end
    end
  end

  directed_row_t directed_rows [] = '{
    '{REQ_TOP,   16'h0000, 4'd5,  1'b1, ST_OK, 24'd0, 24'd0},
    '{REQ_COVER, 16'h0003, 4'd1,  1'b1, ST_OK, 24'd0, 24'd0},
    '{REQ_ADD,   16'hffff, 4'd0,  1'b1, ST_OK, 24'd0, 24'd1},
    '{REQ_ADD,   16'h0000, 4'd15, 1'b1, ST_OK, 24'd0, 24'd2},
    '{REQ_ADD,   16'hffff, 4'd0,  1'b0, ST_OK, 24'd0, 24'd0},
    '{REQ_ADD,   16'h0013, 4'd0,  1'b0, ST_OK, 24'd0, 24'd0},
    '{REQ_ADD,   16'h5a5f, 4'd0,  1'b0, ST_OK, 24'd0, 24'd0},
    '{REQ_COVER, 16'h0003, 4'd0,  1'b0, ST_OK, 24'd0, 24'd0},
    '{REQ_COVER, 16'h000f, 4'd0,  1'b0, ST_OK, 24'd0, 24'd0},
    '{REQ_COVER, 16'hffff, 4'd0,  1'b1, ST_OK, 24'd0, 24'd5},
    '{REQ_COVER, 16'h0010, 4'd0,  1'b1, ST_OK, 24'd0, 24'd5},
    '{REQ_TOP,   16'h0000, 4'd0,  1'b1, ST_OK, 24'd0, 24'd5},
    '{REQ_TOP,   16'h0000, 4'd15, 1'b0, ST_OK, 24'd0, 24'd0},
    '{REQ_TOP,   16'h0000, 4'd1,  1'b0, ST_OK, 24'd0, 24'd0},
    '{REQ_TOP,   16'h0000, 4'd8,  1'b0, ST_OK, 24'd0, 24'd0},
    '{REQ_MERGE, 16'h0000, 4'd0,  1'b0, ST_OK, 24'd0, 24'd0},
    '{REQ_TOP,   16'h0000, 4'd9,  1'b0, ST_OK, 24'd0, 24'd0},
    '{REQ_BAD_LO, 16'hffff, 4'd15, 1'b1, ST_OK, 24'd0, 24'd5},
    '{REQ_BAD_MID, 16'h1234, 4'd3, 1'b1, ST_OK, 24'd0, 24'd5},
    '{REQ_BAD_HI, 16'h0000, 4'd0, 1'b1, ST_OK, 24'd0, 24'd5},
    '{REQ_CLEAR, 16'h0000, 4'd0,  1'b1, ST_OK, 24'd0, 24'd0},
    '{REQ_TOP,   16'h0000, 4'd8,  1'b1, ST_OK, 24'd0, 24'd0}
  };

  initial begin
    table_result_t typed_result;
    logic [2:0] req;
    logic [15:0] key;
    int pick;
    model_used = 0;
    model_total = '0;
    for (int i = 0; i < 80; i++) key_pool[i] = 16'($urandom_range(0, 16'hffff));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      typed_result = '0;
      typed_result.st = directed_rows[i].st;
      typed_result.sum = directed_rows[i].sum;
      typed_result.tot = directed_rows[i].tot;
      typed_result.lst = 1'b1;
      send_request(directed_rows[i].req, directed_rows[i].key, directed_rows[i].lim,
                   directed_rows[i].typed, typed_result);
    end

    // fill past capacity first, then a mixed workload
    for (int n = 0; n < 400; n++) begin
      pick = $urandom_range(0, 99);
      key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 79)]
                                       : 16'($urandom_range(0, 16'hffff));
      if (n < 90 || pick < 55) req = REQ_ADD;
      else if (pick < 57) req = REQ_CLEAR;
      else if (pick < 72) begin
        req = REQ_COVER;
        key = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 15))
                                          : 16'($urandom_range(0, 16'hffff));
      end
      else if (pick < 90) req = REQ_TOP;
      else if (pick < 95) req = REQ_MERGE;
      else req = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
      send_request(req, key, 4'($urandom_range(0, 15)), 1'b0, '0);
    end
    @(negedge clk);
    start = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[kmer_count_table_unit] OK");
    end else begin
      $display("[kmer_count_table_unit] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

### kmer_count_table_unit.f
+incdir+rtl
rtl/kct_pkg.sv
rtl/kct_store.sv
rtl/kmer_count_table_unit.sv
rtl/kct_checker.sv
tb/kmer_count_table_unit_tb.sv
